>>> rtl/core/irdl_pkg.sv
`timescale 1ns / 1ps

package irdl_pkg;

    // input kinds
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_FRAME  = 2'd1;
    localparam logic [1:0] ACT_TORQUE = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_STATUS_PERIOD = 3'd0;
    localparam logic [2:0] CFG_RPM_PERIOD    = 3'd1;
    localparam logic [2:0] CFG_LINK_TIMEOUT  = 3'd2;
    localparam logic [2:0] CFG_HOLD_TIME     = 3'd3;
    localparam logic [2:0] CFG_BUZZER_TIME   = 3'd4;
    localparam logic [2:0] CFG_REISSUE_TIME  = 3'd5;

    localparam logic [10:0] RX_ID      = 11'h181;
    localparam logic [3:0]  RX_MIN_LEN = 4'd3;
    localparam logic [7:0]  REG_STATUS = 8'h40;
    localparam logic [7:0]  REG_RPM    = 8'h30;
    localparam logic [7:0]  REG_VBUS   = 8'hEB;
    localparam logic [15:0] FAULT_MASK = 16'h0040;

    localparam logic [7:0] CMD_REQUEST = 8'h3D;
    localparam logic [7:0] CMD_CLEAR   = 8'h8E;
    localparam logic [7:0] CMD_MODE    = 8'h51;
    localparam logic [7:0] CMD_TORQUE  = 8'h90;
    localparam logic [7:0] CMD_TIMEOUT = 8'hD0;
    localparam logic [7:0] MODE_LOCK   = 8'h04;

    localparam int unsigned MAX_FRAMES = 5;

    typedef struct packed {
        logic [1:0]         action;
        logic               button_pressed;
        logic [10:0]        frame_id;
        logic [3:0]         frame_len;
        logic [7:0]         frame_reg;
        logic [7:0]         frame_lo;
        logic [7:0]         frame_hi;
        logic signed [15:0] torque_request;
    } t_in_item;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_command;
        logic [7:0]         tx_arg_lo;
        logic [7:0]         tx_arg_hi;
        logic               last_result;
        logic               ready_to_drive;
        logic               fault_active;
        logic               buzzer_on;
        logic [15:0]        status_word;
        logic signed [15:0] motor_rpm;
        logic [15:0]        dc_bus_decivolts;
    } t_out_item;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_frame;

    typedef struct packed {
        logic [7:0]  status_period;
        logic [7:0]  rpm_period;
        logic [15:0] link_timeout;
        logic [15:0] hold_time;
        logic [15:0] buzzer_time;
        logic [15:0] reissue_time;
    } t_cfg;

endpackage

>>> rtl/core/irdl_if.sv
`timescale 1ns / 1ps

interface irdl_in_if import irdl_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irdl_out_if import irdl_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irdl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  idx;
    logic [15:0] wdata;

    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

>>> rtl/core/inverter_ready_to_drive_link_top.sv
`timescale 1ns / 1ps

// Inverter link and ready-to-drive interlock.
// i_in takes one request per item: a 1 ms tick, a received frame, a torque
// request or a start. o_out delivers one to five results per item; each
// carries an optional three-byte command frame, last_result on the final
// one, and the status as it stands after the whole item. i_cfg writes the
// six timing/period registers (always ready).
// An accepted item is decoded in the accept cycle and its first result is
// valid on the next cycle. Results leave one per cycle from the frame
// buffer while the receiver takes them; the next item is taken in the cycle
// its last result is taken, so back-to-back single-result items run at one
// per cycle when the receiver is ready.
// Reset clears all status and timers, the result count and index (not the
// frames), and loads the register defaults. When the receiver stalls, the
// current result holds; i_in stays not ready until its last result is taken.
module inverter_ready_to_drive_link_top import irdl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    irdl_in_if.sink    i_in,
    irdl_out_if.source o_out,
    irdl_cfg_if.sink   i_cfg
);

    t_cfg cfg;

    irdl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid & i_cfg.ready),
        .i_idx   (i_cfg.idx),
        .i_wdata (i_cfg.wdata),
        .o_cfg   (cfg)
    );

    assign i_cfg.ready = 1'b1;

    // interlock state
    logic        r_rtd, r_fault, r_hold_active;
    logic [15:0] r_status, r_rpm, r_dcbus, r_prev_torque;
    logic [15:0] r_hold_ticks, r_buzzer_ticks, r_reissue_ticks;
    logic        n_rtd, n_fault, n_hold_active;
    logic [15:0] n_status, n_rpm, n_dcbus, n_prev_torque;
    logic [15:0] n_hold_ticks, n_buzzer_ticks, n_reissue_ticks;

    // result buffer
    t_frame      r_frm [MAX_FRAMES];
    t_frame      n_frm [MAX_FRAMES];
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_idx;
    logic        r_busy;

    logic        take, last_now, accept;
    logic        reiss, grant, pressed;
    logic        hact_mid;
    logic [15:0] htk_mid;
    logic [15:0] val;
    t_in_item    in_d;

    assign in_d     = i_in.data;
    assign take     = o_out.valid & o_out.ready;
    assign last_now = (r_cnt == 3'd0) || ((r_idx + 3'd1) == r_cnt);
    assign i_in.ready = !r_busy || (o_out.ready && last_now);
    assign accept   = i_in.valid & i_in.ready;

    always_comb begin
        n_rtd           = r_rtd;
        n_fault         = r_fault;
        n_hold_active   = r_hold_active;
        n_status        = r_status;
        n_rpm           = r_rpm;
        n_dcbus         = r_dcbus;
        n_prev_torque   = r_prev_torque;
        n_hold_ticks    = r_hold_ticks;
        n_buzzer_ticks  = r_buzzer_ticks;
        n_reissue_ticks = r_reissue_ticks;
        n_cnt           = 3'd0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            n_frm[k] = '0;
        end

        pressed  = in_d.button_pressed;
        reiss    = r_reissue_ticks >= cfg.reissue_time;
        val      = {in_d.frame_hi, in_d.frame_lo};
        hact_mid = r_hold_active;
        htk_mid  = r_hold_ticks;
        grant    = 1'b0;

        unique case (in_d.action)
            ACT_TICK: begin
                if (reiss) begin
                    n_frm[0] = '{CMD_REQUEST, REG_STATUS, cfg.status_period};
                    n_frm[1] = '{CMD_REQUEST, REG_RPM, cfg.rpm_period};
                    n_reissue_ticks = '0;
                end else begin
                    n_reissue_ticks = r_reissue_ticks + 16'd1;
                end

                if (r_buzzer_ticks != 16'd0) begin
                    n_buzzer_ticks = r_buzzer_ticks - 16'd1;
                end

                if (!pressed) begin
                    hact_mid = 1'b0;
                    htk_mid  = '0;
                end else if (r_hold_active && r_hold_ticks != 16'hFFFF) begin
                    htk_mid = r_hold_ticks + 16'd1;
                end

                // a fresh press starts the hold at zero
                if (pressed && !r_rtd && !r_fault && !hact_mid) begin
                    hact_mid = 1'b1;
                    htk_mid  = '0;
                end

                grant = pressed && !r_rtd && !r_fault && (htk_mid >= cfg.hold_time);
                n_hold_active = grant ? 1'b0 : hact_mid;
                n_hold_ticks  = grant ? 16'd0 : htk_mid;

                if (grant) begin
                    n_rtd          = 1'b1;
                    n_buzzer_ticks = cfg.buzzer_time;
                    if (reiss) begin
                        n_frm[2] = '{CMD_CLEAR, 8'h00, 8'h00};
                        n_frm[3] = '{CMD_MODE, MODE_LOCK, 8'h00};
                        n_frm[4] = '{CMD_MODE, 8'h00, 8'h00};
                    end else begin
                        n_frm[0] = '{CMD_CLEAR, 8'h00, 8'h00};
                        n_frm[1] = '{CMD_MODE, MODE_LOCK, 8'h00};
                        n_frm[2] = '{CMD_MODE, 8'h00, 8'h00};
                    end
                end
                n_cnt = (reiss ? 3'd2 : 3'd0) + (grant ? 3'd3 : 3'd0);
            end
            ACT_FRAME: begin
                if (in_d.frame_id == RX_ID && in_d.frame_len >= RX_MIN_LEN) begin
                    unique case (in_d.frame_reg)
                        REG_STATUS: begin
                            n_status = val;
                            n_fault  = (val & FAULT_MASK) != 16'd0;
                            if ((val & FAULT_MASK) != 16'd0) begin
                                n_rtd = 1'b0;
                            end
                        end
                        REG_RPM:  n_rpm   = val;
                        REG_VBUS: n_dcbus = val;
                        default: ;
                    endcase
                end
            end
            ACT_TORQUE: begin
                if (r_rtd && !r_fault && 16'(in_d.torque_request) != r_prev_torque) begin
                    n_frm[0] = '{CMD_TORQUE, in_d.torque_request[7:0],
                                 in_d.torque_request[15:8]};
                    n_cnt         = 3'd1;
                    n_prev_torque = 16'(in_d.torque_request);
                end
            end
            ACT_START: begin
                n_frm[0] = '{CMD_CLEAR, 8'h00, 8'h00};
                n_frm[1] = '{CMD_TIMEOUT, cfg.link_timeout[7:0], cfg.link_timeout[15:8]};
                n_frm[2] = '{CMD_REQUEST, REG_STATUS, cfg.status_period};
                n_frm[3] = '{CMD_REQUEST, REG_RPM, cfg.rpm_period};
                n_frm[4] = '{CMD_REQUEST, REG_VBUS, 8'h00};
                n_cnt    = 3'd5;
                n_reissue_ticks = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtd           <= 1'b0;
            r_fault         <= 1'b0;
            r_hold_active   <= 1'b0;
            r_status        <= '0;
            r_rpm           <= '0;
            r_dcbus         <= '0;
            r_prev_torque   <= '0;
            r_hold_ticks    <= '0;
            r_buzzer_ticks  <= '0;
            r_reissue_ticks <= '0;
            r_busy          <= 1'b0;
            r_cnt           <= '0;
            r_idx           <= '0;
        end else if (accept) begin
            r_rtd           <= n_rtd;
            r_fault         <= n_fault;
            r_hold_active   <= n_hold_active;
            r_status        <= n_status;
            r_rpm           <= n_rpm;
            r_dcbus         <= n_dcbus;
            r_prev_torque   <= n_prev_torque;
            r_hold_ticks    <= n_hold_ticks;
            r_buzzer_ticks  <= n_buzzer_ticks;
            r_reissue_ticks <= n_reissue_ticks;
            r_busy          <= 1'b1;
            r_cnt           <= n_cnt;
            r_idx           <= '0;
        end else if (take) begin
            if (last_now) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_frm[k] <= n_frm[k];
            end
        end
    end

    t_frame cur;

    always_comb begin
        cur = (r_cnt == 3'd0) ? t_frame'('0) : r_frm[r_idx];
        o_out.valid                 = r_busy;
        o_out.data.tx_valid         = r_cnt != 3'd0;
        o_out.data.tx_command       = cur.cmd;
        o_out.data.tx_arg_lo        = cur.lo;
        o_out.data.tx_arg_hi        = cur.hi;
        o_out.data.last_result      = last_now;
        o_out.data.ready_to_drive   = r_rtd;
        o_out.data.fault_active     = r_fault;
        o_out.data.buzzer_on        = r_buzzer_ticks != 16'd0;
        o_out.data.status_word      = r_status;
        o_out.data.motor_rpm        = signed'(r_rpm);
        o_out.data.dc_bus_decivolts = r_dcbus;
    end

endmodule

>>> rtl/core/irdl_cfg.sv
`timescale 1ns / 1ps

module irdl_cfg import irdl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [2:0]  i_idx,
    input  logic [15:0] i_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_period <= 8'd10;
            r_cfg.rpm_period    <= 8'd10;
            r_cfg.link_timeout  <= 16'd100;
            r_cfg.hold_time     <= 16'd1000;
            r_cfg.buzzer_time   <= 16'd3000;
            r_cfg.reissue_time  <= 16'd5000;
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_STATUS_PERIOD: r_cfg.status_period <= i_wdata[7:0];
                CFG_RPM_PERIOD:    r_cfg.rpm_period    <= i_wdata[7:0];
                CFG_LINK_TIMEOUT:  r_cfg.link_timeout  <= i_wdata;
                CFG_HOLD_TIME:     r_cfg.hold_time     <= i_wdata;
                CFG_BUZZER_TIME:   r_cfg.buzzer_time   <= i_wdata;
                CFG_REISSUE_TIME:  r_cfg.reissue_time  <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
